// ===== rtl/periodic_pair_distance_defines.svh =====
// Assertion macros used by the port-level checker.
`ifndef PERIODIC_PAIR_DISTANCE_DEFINES_SVH
`define PERIODIC_PAIR_DISTANCE_DEFINES_SVH

// Checked on clk, quiet while rst_n is low.
`define PPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("periodic_pair_distance check failed");

// Checked on clk, also while rst_n is low.
`define PPD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("periodic_pair_distance reset check failed");

`endif

// ===== rtl/ppd_pkg.sv =====
// Shared constants and types for the periodic pair distance block.
`default_nettype none
package ppd_pkg;
  localparam int DEF_MAX_PARTICLES = 64;
  localparam int COORD_W  = 32;
  localparam int BOX_W    = 31;
  localparam int INV_W    = 48;
  localparam int FOLD_W   = 33;
  localparam int DIST_W   = 32;
  localparam int IDX_OUT_W = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_BOX_LENGTH = 1'd1;

  localparam logic [BOX_W-1:0] BOX_RESET = 31'd65536;
  localparam logic [INV_W-1:0] INV_RESET = 48'h0001_0000_0000;

  // Result of the merge stage.
  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] dist_val;
  } ppd_dist_t;
endpackage
`default_nettype wire

// ===== rtl/ppd_lane.sv =====
// One axis lane: minimum-image fold of a coordinate difference, magnitude out.
`default_nettype none
module ppd_lane (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [ppd_pkg::COORD_W-1:0]    coord_old,
  input  wire logic [ppd_pkg::COORD_W-1:0]    coord_new,
  input  wire logic [ppd_pkg::BOX_W-1:0]      box_len,
  input  wire logic [ppd_pkg::INV_W-1:0]      inv_len,
  output logic                                fold_valid,
  output logic [ppd_pkg::FOLD_W-1:0]          fold_mag
);
  logic [4:0]  vld_r;
  logic signed [32:0] diff;
  logic [32:0] m0_r, m1_r, m2_r, m3_r;
  logic [64:0] plo_r;
  logic [48:0] phi_r;
  logic [65:0] lo_rnd;
  logic [49:0] q_nxt, q_r;
  logic        sat2_r, sat3_r;
  logic [64:0] p_r;
  logic [64:0] n_diff;
  logic [32:0] fold_nxt, fold_r;

  assign diff   = {coord_old[31], coord_old} - {coord_new[31], coord_new};
  assign lo_rnd = 66'(plo_r) + 66'h8000_0000;
  assign q_nxt  = 50'(phi_r) + 50'(lo_rnd[65:32]);

  // fold: |p - m| clamped to 2^32, or m - p
  always_comb begin
    n_diff = p_r - 65'(m3_r);
    if (sat3_r) begin
      fold_nxt = 33'h1_0000_0000;
    end else if (p_r >= 65'(m3_r)) begin
      fold_nxt = (n_diff > 65'h1_0000_0000) ? 33'h1_0000_0000 : n_diff[32:0];
    end else begin
      fold_nxt = 33'(65'(m3_r) - p_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], start};
    end
    m0_r   <= diff[32] ? 33'(-diff) : 33'(diff);
    plo_r  <= 65'(m0_r) * 65'(inv_len[31:0]);
    phi_r  <= 49'(m0_r) * 49'(inv_len[47:32]);
    m1_r   <= m0_r;
    q_r    <= q_nxt;
    sat2_r <= (q_nxt > 50'h2_0000_0000) && (box_len != '0);
    m2_r   <= m1_r;
    p_r    <= 65'(box_len) * 65'(q_r[33:0]);
    sat3_r <= sat2_r;
    m3_r   <= m2_r;
    fold_r <= fold_nxt;
  end

  assign fold_valid = vld_r[4];
  assign fold_mag   = fold_r;
endmodule
`default_nettype wire

// ===== rtl/ppd_merge.sv =====
// Merge stage: sum of squares of the three lanes, then bitwise square root.
`default_nettype none
module ppd_merge (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        fold_valid,
  input  wire logic [ppd_pkg::FOLD_W-1:0]  fx,
  input  wire logic [ppd_pkg::FOLD_W-1:0]  fy,
  input  wire logic [ppd_pkg::FOLD_W-1:0]  fz,
  output ppd_pkg::ppd_dist_t               res
);
  logic        sq_vld_r, busy_r, done_r;
  logic        sat_r, sat_sum_r;
  logic [63:0] sqx_r, sqy_r, sqz_r;
  logic [65:0] sum;
  logic [4:0]  cnt_r;
  logic [63:0] rad_r;
  logic [33:0] rem_r, rem_sh, trial;
  logic [31:0] root_r, root_nxt;
  logic [33:0] rem_nxt;
  logic [31:0] dist_r;

  assign sum    = 66'(sqx_r) + 66'(sqy_r) + 66'(sqz_r);
  assign rem_sh = {rem_r[31:0], rad_r[63:62]};
  assign trial  = {root_r, 2'b01};

  always_comb begin
    if (rem_sh >= trial) begin
      rem_nxt  = rem_sh - trial;
      root_nxt = {root_r[30:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh;
      root_nxt = {root_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      busy_r   <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      sq_vld_r <= fold_valid;
      done_r   <= 1'b0;
      if (sq_vld_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
    sat_r <= fx[32] | fy[32] | fz[32];
    sqx_r <= 64'(fx[31:0]) * 64'(fx[31:0]);
    sqy_r <= 64'(fy[31:0]) * 64'(fy[31:0]);
    sqz_r <= 64'(fz[31:0]) * 64'(fz[31:0]);
    if (sq_vld_r) begin
      rad_r     <= sum[63:0];
      sat_sum_r <= sat_r | (sum[65:64] != 2'b00);
      rem_r     <= '0;
      root_r    <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[61:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      if (cnt_r == 5'd31) begin
        dist_r <= sat_sum_r ? 32'hFFFF_FFFF : root_nxt;
      end
    end
  end

  assign res.done     = done_r;
  assign res.dist_val = dist_r;
endmodule
`default_nettype wire

// ===== rtl/periodic_pair_distance.sv =====
// Top level of the periodic pair distance block: store, sequencer, lanes, merge.
// Usage:
//  - Input channel (in_valid / in_stall): one particle per transaction, x/y/z
//    in signed Q16.16 plus new_set, which empties the store first.
//  - Output channel (out_valid / out_stall): one transaction per particle
//    stored earlier, in index order, with both indices, the minimum-image
//    distance (Q16.16, truncated) and last on the final one.
//  - Config port (cfg_we / cfg_index / cfg_data): box length and its
//    reciprocal; write only while the block is idle.
// Flow:
//  - Each pair runs once through three parallel axis lanes and the merge
//    stage (squares and sum, then a bitwise square root), plus fetch,
//    launch and send; only one pair is in flight at a time.
//  - A particle with n earlier ones yields n results; in_stall is high from
//    acceptance until its last result is taken.
//  - The first particle of a set, or one arriving to a full store without
//    new_set, produces no result and leaves the block idle.
// Reset: the particle count clears, registers return to L = 1.0 and
// 1/L = 1.0; store contents are left as they are.
// A stalled result holds on the outputs; the pipeline waits behind it.
`default_nettype none
module periodic_pair_distance #(
  parameter int MAX_PARTICLES = ppd_pkg::DEF_MAX_PARTICLES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [ppd_pkg::COORD_W-1:0]      in_pos_x,
  input  wire logic [ppd_pkg::COORD_W-1:0]      in_pos_y,
  input  wire logic [ppd_pkg::COORD_W-1:0]      in_pos_z,
  input  wire logic                             in_new_set,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [ppd_pkg::IDX_OUT_W-1:0]         out_older_index,
  output logic [ppd_pkg::IDX_OUT_W-1:0]         out_newer_index,
  output logic [ppd_pkg::DIST_W-1:0]            out_distance,
  output logic                                  out_last,
  input  wire logic                             cfg_we,
  input  wire logic [ppd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ppd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam int IW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam int PW = 3 * ppd_pkg::COORD_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_START = 5'b00100,
    S_CALC  = 5'b01000,
    S_SEND  = 5'b10000
  } state_t;

  state_t state_r;
  logic [CW-1:0] count_r, count_eff;
  logic [IW-1:0] i_r, n_r;
  logic [ppd_pkg::BOX_W-1:0] box_r;
  logic [ppd_pkg::INV_W-1:0] inv_r;

  // particle store: x, y, z packed, one write and one read port
  logic [PW-1:0] store_mem [MAX_PARTICLES];
  logic [PW-1:0] rd_data_r;
  logic [PW-1:0] new_pos_r;

  logic accept, full, start;
  logic [2:0] lane_vld;
  logic [ppd_pkg::FOLD_W-1:0] fold [3];
  ppd_pkg::ppd_dist_t mres;

  logic out_valid_r, out_last_r;
  logic [ppd_pkg::DIST_W-1:0] out_dist_r;
  logic [IW-1:0] out_older_r, out_newer_r;

  assign accept    = in_valid && !in_stall;
  assign count_eff = in_new_set ? '0 : count_r;
  assign full      = (count_eff >= CW'(MAX_PARTICLES));
  assign start     = (state_r == S_START);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r <= ppd_pkg::BOX_RESET;
      inv_r <= ppd_pkg::INV_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppd_pkg::CFG_BOX_LENGTH:     box_r <= cfg_data[ppd_pkg::BOX_W-1:0];
        ppd_pkg::CFG_INV_BOX_LENGTH: inv_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !full) begin
      store_mem[count_eff[IW-1:0]] <= {in_pos_z, in_pos_y, in_pos_x};
      new_pos_r <= {in_pos_z, in_pos_y, in_pos_x};
    end
    rd_data_r <= store_mem[i_r];
  end

  // sequencer: walk older particles one pair at a time
  // new_set never meets a full store, so the count restarts through count_eff
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      i_r         <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (!full) begin
              count_r <= count_eff + CW'(1);
              n_r     <= count_eff[IW-1:0];
              i_r     <= '0;
              if (count_eff != '0) state_r <= S_FETCH;
            end
          end
        end
        S_FETCH: state_r <= S_START;
        S_START: state_r <= S_CALC;
        S_CALC: begin
          if (mres.done) begin
            out_valid_r <= 1'b1;
            state_r     <= S_SEND;
          end
        end
        S_SEND: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + IW'(1);
              state_r <= S_FETCH;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // result register, loaded as the merge finishes
  always_ff @(posedge clk) begin
    if (state_r == S_CALC && mres.done) begin
      out_dist_r  <= mres.dist_val;
      out_older_r <= i_r;
      out_newer_r <= n_r;
      out_last_r  <= (i_r == n_r - IW'(1));
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    ppd_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .start      (start),
      .coord_old  (rd_data_r[g*ppd_pkg::COORD_W +: ppd_pkg::COORD_W]),
      .coord_new  (new_pos_r[g*ppd_pkg::COORD_W +: ppd_pkg::COORD_W]),
      .box_len    (box_r),
      .inv_len    (inv_r),
      .fold_valid (lane_vld[g]),
      .fold_mag   (fold[g])
    );
  end

  ppd_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .fold_valid (lane_vld[0] & lane_vld[1] & lane_vld[2]),
    .fx         (fold[0]),
    .fy         (fold[1]),
    .fz         (fold[2]),
    .res        (mres)
  );

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_distance    = out_dist_r;
  assign out_last        = out_last_r;
  assign out_older_index = ppd_pkg::IDX_OUT_W'(out_older_r);
  assign out_newer_index = ppd_pkg::IDX_OUT_W'(out_newer_r);
endmodule
`default_nettype wire

// ===== rtl/ppd_checker.sv =====
// Port-level checker for periodic_pair_distance, bound to the top level.
`default_nettype none
`include "periodic_pair_distance_defines.svh"
module ppd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [5:0]  out_older_index,
  input wire logic [5:0]  out_newer_index,
  input wire logic [31:0] out_distance,
  input wire logic        out_last
);
  `PPD_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid)
  `PPD_ASSERT(a_busy_while_result, out_valid |-> in_stall)
  `PPD_ASSERT(a_hold_stalled, out_valid && out_stall |=> out_valid && $stable(out_distance))
  `PPD_ASSERT(a_last_index, out_valid && out_last |-> (out_older_index + 6'd1) == out_newer_index)
endmodule

bind periodic_pair_distance ppd_checker u_ppd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_older_index (out_older_index),
  .out_newer_index (out_newer_index),
  .out_distance    (out_distance),
  .out_last        (out_last)
);
`default_nettype wire

// ===== tb/periodic_pair_distance_tb.sv =====
// Self-checking testbench for periodic_pair_distance: directed table, random sets, checker.
`timescale 1ns / 1ps
module periodic_pair_distance_tb;

  localparam int STORE_DEPTH = ppd_pkg::DEF_MAX_PARTICLES;
  localparam int LIMIT_CYCLES = 2_000_000;
  // Cycles to let a result-free transaction clear before a register write.
  localparam int SETTLE_CYCLES = 60;

  typedef struct {
    bit                        new_set;
    bit [ppd_pkg::COORD_W-1:0] x;
    bit [ppd_pkg::COORD_W-1:0] y;
    bit [ppd_pkg::COORD_W-1:0] z;
  } particle_t;

  typedef struct {
    bit [ppd_pkg::IDX_OUT_W-1:0] older;
    bit [ppd_pkg::IDX_OUT_W-1:0] newer;
    bit [ppd_pkg::DIST_W-1:0]    dist_val;
    bit                          last;
  } pair_t;

  // Directed row: chk marks a row whose single distance is typed in.
  typedef struct {
    particle_t                p;
    bit                       chk;
    bit [ppd_pkg::DIST_W-1:0] dist_val;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ppd_pkg::COORD_W-1:0] in_pos_x = '0;
  logic [ppd_pkg::COORD_W-1:0] in_pos_y = '0;
  logic [ppd_pkg::COORD_W-1:0] in_pos_z = '0;
  logic in_new_set = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ppd_pkg::IDX_OUT_W-1:0] out_older_index;
  logic [ppd_pkg::IDX_OUT_W-1:0] out_newer_index;
  logic [ppd_pkg::DIST_W-1:0] out_distance;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [ppd_pkg::CFG_IDX_W-1:0] cfg_index = ppd_pkg::CFG_BOX_LENGTH;
  logic [ppd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  periodic_pair_distance dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_new_set(in_new_set),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_older_index(out_older_index), .out_newer_index(out_newer_index),
    .out_distance(out_distance), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: its own copy of the store and of both registers.
  bit [ppd_pkg::COORD_W-1:0] mem_x [STORE_DEPTH];
  bit [ppd_pkg::COORD_W-1:0] mem_y [STORE_DEPTH];
  bit [ppd_pkg::COORD_W-1:0] mem_z [STORE_DEPTH];
  int unsigned stored_cnt = 0;
  longint unsigned box_len = 64'd65536;
  longint unsigned inv_len = 64'd1 << 32;

  pair_t pending_pairs[$];
  int errors = 0;
  int pairs_seen = 0;
  int accepted = 0;
  int ignored = 0;
  bit calm = 1'b0;     // no idling on either side while set
  bit hold_go = 1'b0;  // one-shot request for a long receiver hold-off
  int cycle_cnt = 0;

  // |d - L*q| for one axis, clamped at 2^32 (that value means saturate).
  function automatic longint unsigned fold_mag(bit [ppd_pkg::COORD_W-1:0] a,
                                               bit [ppd_pkg::COORD_W-1:0] b);
    longint d;
    longint unsigned m, hi, lo, q, p, n;
    d = longint'($signed(a)) - longint'($signed(b));
    m = (d < 0) ? longint'(-d) : longint'(d);
    hi = inv_len >> 32;
    lo = inv_len & 64'hFFFF_FFFF;
    q = m * hi + ((m * lo + 64'h8000_0000) >> 32);
    if (q > (64'd1 << 33) && box_len != 0)
      return 64'd1 << 32;
    p = box_len * q;
    if (p >= m) begin
      n = p - m;
      return (n > (64'd1 << 32)) ? (64'd1 << 32) : n;
    end
    return m - p;
  endfunction

  // Bitwise integer square root, floor.
  function automatic bit [31:0] root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic bit [ppd_pkg::DIST_W-1:0] image_distance(int i, particle_t p);
    longint unsigned f[3];
    longint unsigned sum, sq;
    sum = 0;
    f[0] = fold_mag(mem_x[i], p.x);
    f[1] = fold_mag(mem_y[i], p.y);
    f[2] = fold_mag(mem_z[i], p.z);
    for (int k = 0; k < 3; k++) begin
      if (f[k] >= (64'd1 << 32)) return 32'hFFFF_FFFF;
      sq = f[k] * f[k];
      if (sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) return 32'hFFFF_FFFF;
      sum = sum + sq;
    end
    return root_floor(sum);
  endfunction

  // Queue every distance the accepted particle causes, then store it.
  task automatic store_particle(particle_t p);
    pair_t r;
    if (p.new_set) stored_cnt = 0;
    if (stored_cnt >= STORE_DEPTH) begin
      ignored++;
      return;
    end
    for (int i = 0; i < stored_cnt; i++) begin
      r.older = i[ppd_pkg::IDX_OUT_W-1:0];
      r.newer = stored_cnt[ppd_pkg::IDX_OUT_W-1:0];
      r.dist_val = image_distance(i, p);
      r.last = (i + 1 == stored_cnt);
      pending_pairs.push_back(r);
    end
    mem_x[stored_cnt] = p.x;
    mem_y[stored_cnt] = p.y;
    mem_z[stored_cnt] = p.z;
    stored_cnt++;
  endtask

  // Offer one transaction, sometimes with a random idle gap ahead of it.
  task automatic send_particle(particle_t p);
    if (!calm && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= p.x;
    in_pos_y <= p.y;
    in_pos_z <= p.z;
    in_new_set <= p.new_set;
    do @(posedge clk); while (in_stall);
    accepted++;
    store_particle(p);
  endtask

  // Block must be drained and quiet before touching a register.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [ppd_pkg::CFG_IDX_W-1:0] idx, longint unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[ppd_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == ppd_pkg::CFG_BOX_LENGTH) box_len = val & 64'h7FFF_FFFF;
    else inv_len = val & 64'hFFFF_FFFF_FFFF;
  endtask

  task automatic set_box(longint unsigned len, longint unsigned inv);
    drain();
    write_reg(ppd_pkg::CFG_BOX_LENGTH, len);
    write_reg(ppd_pkg::CFG_INV_BOX_LENGTH, inv);
  endtask

  // Half clustered near a base so the fold matters; the rest wild or extreme values.
  function automatic bit [ppd_pkg::COORD_W-1:0] pick_coord(bit [ppd_pkg::COORD_W-1:0] base,
                                                           int spread);
    bit [ppd_pkg::COORD_W-1:0] corner[4];
    corner[0] = 32'h7FFF_FFFF;
    corner[1] = 32'h8000_0000;
    corner[2] = 32'h0000_0000;
    corner[3] = 32'hFFFF_FFFF;
    case ($urandom_range(0, 5))
      0, 1, 2: return base + $urandom_range(0, spread) - spread / 2;
      3, 4: return $urandom;
      default: return corner[$urandom_range(0, 3)];
    endcase
  endfunction

  // A set of n particles sharing one neighborhood.
  task automatic send_set(int n, int spread);
    particle_t p;
    bit [ppd_pkg::COORD_W-1:0] bx, by, bz;
    bx = $urandom;
    by = $urandom;
    bz = $urandom;
    for (int k = 0; k < n; k++) begin
      p.new_set = (k == 0);
      p.x = pick_coord(bx, spread);
      p.y = pick_coord(by, spread);
      p.z = pick_coord(bz, spread);
      send_particle(p);
    end
  endtask

  // Result checker and receiver stall generation.
  int hold_left = 0;
  always @(posedge clk) begin
    pair_t e;
    if (rst_n && out_valid && !out_stall) begin
      pairs_seen++;
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected result older=%0d newer=%0d dist=%h", $time,
                 out_older_index, out_newer_index, out_distance);
        errors++;
      end else begin
        e = pending_pairs.pop_front();
        if (out_older_index !== e.older) begin
          $display("%0t: older_index expected %0d actual %0d", $time, e.older,
                   out_older_index);
          errors++;
        end
        if (out_newer_index !== e.newer) begin
          $display("%0t: newer_index expected %0d actual %0d", $time, e.newer,
                   out_newer_index);
          errors++;
        end
        if (out_distance !== e.dist_val) begin
          $display("%0t: distance expected %h actual %h", $time, e.dist_val,
                   out_distance);
          errors++;
        end
        if (out_last !== e.last) begin
          $display("%0t: last expected %0d actual %0d", $time, e.last, out_last);
          errors++;
        end
      end
    end
    // Long hold-off: the block holds its result and must stall its input.
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 26);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("periodic_pair_distance_tb NOT OK");
      $finish;
    end
  end

  dir_row_t dir_tab[] = '{
    // first of a set: stored, no result
    '{'{1'b1, 32'h0, 32'h0, 32'h0}, 1'b0, 32'h0},
    // identical particles: zero distance
    '{'{1'b0, 32'h0, 32'h0, 32'h0}, 1'b1, 32'h0},
    '{'{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0, 32'h0},
    // opposite extremes under the reset box: fold overflows, saturated
    '{'{1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0, 32'h0},
    '{'{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0}, 1'b0, 32'h0},
    '{'{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF}, 1'b1, 32'hFFFF_FFFF},
    '{'{1'b0, 32'h0001_0000, 32'h0, 32'h0}, 1'b0, 32'h0},
    '{'{1'b0, 32'hFFFF_FFFF, 32'h1, 32'h2}, 1'b0, 32'h0},
    '{'{1'b0, 32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001}, 1'b0, 32'h0},
    // mid-set restart
    '{'{1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 32'h5555_AAAA}, 1'b0, 32'h0},
    '{'{1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h5555_AAAA}, 1'b1, 32'h0},
    '{'{1'b0, 32'h1234_5679, 32'h9ABC_DEF0, 32'h5555_AAAA}, 1'b0, 32'h0},
    '{'{1'b0, 32'hEDCB_A987, 32'h6543_2110, 32'hAAAA_5555}, 1'b0, 32'h0},
    '{'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, 32'h0},
    '{'{1'b0, 32'h0, 32'h0, 32'h0}, 1'b0, 32'h0}
  };

  initial begin
    int spins;
    particle_t p;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under the reset register values.
    foreach (dir_tab[i]) begin
      send_particle(dir_tab[i].p);
      if (dir_tab[i].chk) pending_pairs[$].dist_val = dir_tab[i].dist_val;
    end

    // Moderate box, consistent reciprocal.
    set_box(64'd655360, (64'd1 << 32) / 64'd655360);
    for (int s = 0; s < 2; s++) send_set($urandom_range(1, 6), 3 * 655360);

    // Fill the store to the top, then overflow it; receiver holds off partway through.
    calm = 1'b1;
    for (int k = 0; k < 66; k++) begin
      p.new_set = (k == 0);
      p.x = $urandom;
      p.y = $urandom_range(0, 32'h000F_FFFF);
      p.z = $urandom;
      if (k == 40) begin
        calm = 1'b0;
        hold_go = 1'b1;
      end
      send_particle(p);
    end

    // Largest box.
    set_box(64'h7FFF_FFFF, (64'd1 << 32) / 64'h7FFF_FFFF);
    for (int s = 0; s < 2; s++) send_set($urandom_range(1, 5), 32'h7FFF_FFFF);

    // Smallest box.
    set_box(64'd1, 64'd1 << 32);
    for (int s = 0; s < 3; s++) send_set($urandom_range(1, 5), 64);

    // Inconsistent reciprocals at both extremes.
    set_box($urandom_range(1, 32'h7FFF_FFFF), 64'hFFFF_FFFF_FFFF);
    for (int s = 0; s < 2; s++) send_set($urandom_range(2, 5), 1 << 20);
    set_box($urandom_range(1, 1 << 24), 64'd1);
    for (int s = 0; s < 2; s++) send_set($urandom_range(2, 5), 1 << 28);
    in_valid <= 1'b0;

    spins = 0;
    while (pending_pairs.size() != 0 && spins < 200_000) begin
      @(posedge clk);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_pairs.size() != 0) begin
      $display("%0d expected results never arrived", pending_pairs.size());
      errors += pending_pairs.size();
    end

    $display("covered %0d particles (%0d dropped on a full store), %0d distances checked,",
             accepted, ignored, pairs_seen);
    $display("six box settings incl. both register extremes; %0d mismatches", errors);
    if (errors == 0) begin
      $display("periodic_pair_distance_tb OK");
    end else begin
      $display("periodic_pair_distance_tb NOT OK");
    end
    $finish;
  end
endmodule
